@@ hdl/tcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants of the tilt-compensated compass datapath.
// ----------------------------------------------------------------------------
package tcc_pkg;

  // cordic iteration count and unit latencies
  localparam int ITERS      = 16;
  localparam int SQRT_LAT   = 32;
  localparam int ATAN_LAT   = ITERS + 1;
  localparam int SINCOS_LAT = ITERS;

  // datapath widths: atan2 operands, angles (q3.16 rad), sin/cos (q.16)
  localparam int CW = 40;
  localparam int AW = 20;
  localparam int SW = 20;

  localparam logic signed [AW-1:0] HALF_PI_Q16  = AW'(102944);
  localparam logic signed [AW:0]   TWO_PI_Q16   = (AW+1)'(411775);
  localparam logic signed [SW-1:0] CORDIC_XINIT = SW'(39797);
  localparam logic [21:0]          DEG_MULT     = 22'd3754937;
  localparam logic [10:0]          TILT_MAX     = 11'd90;
  localparam logic [10:0]          HEAD_MAX     = 11'd359;

  // round(atan(2^-i) * 2^16)
  localparam logic signed [AW-1:0] ATAN_TAB [ITERS] = '{
    AW'(51472), AW'(30385), AW'(16055), AW'(8150), AW'(4091), AW'(2047),
    AW'(1024), AW'(512), AW'(256), AW'(128), AW'(64), AW'(32), AW'(16),
    AW'(8), AW'(4), AW'(2)
  };

  typedef struct packed {
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_t;

  typedef struct packed {
    logic signed [7:0] pitch_deg;
    logic signed [7:0] roll_deg;
    logic [8:0]        heading_deg;
  } out_t;

endpackage

@@ hdl/tcc_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_isqrt
// Pipelined floor square root of sum_sq * 2^32, one result bit per stage.
// ----------------------------------------------------------------------------
module tcc_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [31:0] sum_sq,
  output logic        out_valid,
  output logic [31:0] root
);
  import tcc_pkg::*;

  logic [63:0]         rem_r   [SQRT_LAT];
  logic [63:0]         rem_nxt [SQRT_LAT];
  logic [63:0]         res_r   [SQRT_LAT];
  logic [63:0]         res_nxt [SQRT_LAT];
  logic [SQRT_LAT-1:0] vld_r;

  // one restoring step per stage
  always_comb begin
    logic [63:0] rem_in;
    logic [63:0] res_in;
    logic [63:0] bitv;
    logic [63:0] trial;
    for (int k = 0; k < SQRT_LAT; k++) begin
      if (k == 0) begin
        rem_in = {sum_sq, 32'd0};
        res_in = '0;
      end else begin
        rem_in = rem_r[k-1];
        res_in = res_r[k-1];
      end
      bitv  = 64'd1 << (62 - 2 * k);
      trial = res_in + bitv;
      if (rem_in >= trial) begin
        rem_nxt[k] = rem_in - trial;
        res_nxt[k] = (res_in >> 1) + bitv;
      end else begin
        rem_nxt[k] = rem_in;
        res_nxt[k] = res_in >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SQRT_LAT; k++) begin
      rem_r[k] <= rem_nxt[k];
      res_r[k] <= res_nxt[k];
    end
  end

  // valid travels with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SQRT_LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[SQRT_LAT-1];
  assign root      = res_r[SQRT_LAT-1][31:0];

endmodule

@@ hdl/tcc_atan2.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_atan2
// Pipelined vectoring cordic: quadrant pre-rotation stage, then one
// micro-rotation per stage. Both operands zero gives angle zero.
// ----------------------------------------------------------------------------
module tcc_atan2 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic signed [tcc_pkg::CW-1:0] y_in,
  input  logic signed [tcc_pkg::CW-1:0] x_in,
  output logic                          out_valid,
  output logic signed [tcc_pkg::AW-1:0] angle
);
  import tcc_pkg::*;

  logic signed [CW-1:0] x_r   [ATAN_LAT];
  logic signed [CW-1:0] x_nxt [ATAN_LAT];
  logic signed [CW-1:0] y_r   [ATAN_LAT];
  logic signed [CW-1:0] y_nxt [ATAN_LAT];
  logic signed [AW-1:0] z_r   [ATAN_LAT];
  logic signed [AW-1:0] z_nxt [ATAN_LAT];
  logic [ATAN_LAT-1:0]  zero_r;
  logic [ATAN_LAT-1:0]  zero_nxt;
  logic [ATAN_LAT-1:0]  vld_r;

  always_comb begin
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    // pre-rotation into the right half plane
    zero_nxt[0] = (x_in == '0) && (y_in == '0);
    if (x_in < 0) begin
      if (y_in >= 0) begin
        x_nxt[0] = y_in;
        y_nxt[0] = -x_in;
        z_nxt[0] = HALF_PI_Q16;
      end else begin
        x_nxt[0] = -y_in;
        y_nxt[0] = x_in;
        z_nxt[0] = -HALF_PI_Q16;
      end
    end else begin
      x_nxt[0] = x_in;
      y_nxt[0] = y_in;
      z_nxt[0] = '0;
    end
    // micro-rotations driving y to zero
    for (int k = 1; k < ATAN_LAT; k++) begin
      xs = x_r[k-1] >>> (k - 1);
      ys = y_r[k-1] >>> (k - 1);
      zero_nxt[k] = zero_r[k-1];
      if (y_r[k-1] >= 0) begin
        x_nxt[k] = x_r[k-1] + ys;
        y_nxt[k] = y_r[k-1] - xs;
        z_nxt[k] = z_r[k-1] + ATAN_TAB[k-1];
      end else begin
        x_nxt[k] = x_r[k-1] - ys;
        y_nxt[k] = y_r[k-1] + xs;
        z_nxt[k] = z_r[k-1] - ATAN_TAB[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < ATAN_LAT; k++) begin
      x_r[k] <= x_nxt[k];
      y_r[k] <= y_nxt[k];
      z_r[k] <= z_nxt[k];
    end
    zero_r <= zero_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[ATAN_LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[ATAN_LAT-1];
  assign angle     = zero_r[ATAN_LAT-1] ? '0 : z_r[ATAN_LAT-1];

endmodule

@@ hdl/tcc_sincos.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_sincos
// Pipelined rotation cordic giving cos and sin of an angle in q.16.
// ----------------------------------------------------------------------------
module tcc_sincos (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic signed [tcc_pkg::AW-1:0] angle,
  output logic                          out_valid,
  output logic signed [tcc_pkg::SW-1:0] cos_q,
  output logic signed [tcc_pkg::SW-1:0] sin_q
);
  import tcc_pkg::*;

  logic signed [SW-1:0] x_r   [SINCOS_LAT];
  logic signed [SW-1:0] x_nxt [SINCOS_LAT];
  logic signed [SW-1:0] y_r   [SINCOS_LAT];
  logic signed [SW-1:0] y_nxt [SINCOS_LAT];
  logic signed [AW-1:0] z_r   [SINCOS_LAT];
  logic signed [AW-1:0] z_nxt [SINCOS_LAT];
  logic [SINCOS_LAT-1:0] vld_r;

  // one micro-rotation per stage, first stage starts from the gain constant
  always_comb begin
    logic signed [SW-1:0] x_in;
    logic signed [SW-1:0] y_in;
    logic signed [AW-1:0] z_in;
    logic signed [SW-1:0] xs;
    logic signed [SW-1:0] ys;
    for (int k = 0; k < SINCOS_LAT; k++) begin
      if (k == 0) begin
        x_in = CORDIC_XINIT;
        y_in = '0;
        z_in = angle;
      end else begin
        x_in = x_r[k-1];
        y_in = y_r[k-1];
        z_in = z_r[k-1];
      end
      xs = x_in >>> k;
      ys = y_in >>> k;
      if (z_in >= 0) begin
        x_nxt[k] = x_in - ys;
        y_nxt[k] = y_in + xs;
        z_nxt[k] = z_in - ATAN_TAB[k];
      end else begin
        x_nxt[k] = x_in + ys;
        y_nxt[k] = y_in - xs;
        z_nxt[k] = z_in + ATAN_TAB[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SINCOS_LAT; k++) begin
      x_r[k] <= x_nxt[k];
      y_r[k] <= y_nxt[k];
      z_r[k] <= z_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SINCOS_LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[SINCOS_LAT-1];
  assign cos_q     = x_r[SINCOS_LAT-1];
  assign sin_q     = y_r[SINCOS_LAT-1];

endmodule

@@ hdl/tilt_compensated_compass.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_compensated_compass
// Pitch, roll and tilt-compensated heading from one magnetometer and
// accelerometer sample, fully pipelined.
//
//   channel  ports                     direction  handshake
//   input    start, busy, in_item      in         start while busy is low
//   result   out_valid, out_item       out        one-cycle strobe
//
// One item is accepted every cycle; busy is always low.
// Each result leaves in item order after passing through the pipeline:
// squares, 32 square-root stages, two 17-stage atan2 units, 16 sin/cos
// stages, four multiply stages and two degree stages.
// Synchronous reset clears only the valid bits.
// ----------------------------------------------------------------------------
module tilt_compensated_compass (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  tcc_pkg::in_t  in_item,
  output logic          out_valid,
  output tcc_pkg::out_t out_item
);
  import tcc_pkg::*;

  localparam int AXY_DLY = SQRT_LAT;
  localparam int MAG_DLY = SQRT_LAT + ATAN_LAT + SINCOS_LAT;
  localparam int PR_DLY  = SINCOS_LAT + 4 + ATAN_LAT;
  localparam int MW      = 16 + SW;
  localparam int TW      = MW + 1;
  localparam int UW      = TW + SW;
  localparam int PW      = AW + 1 + 22;

  assign busy = 1'b0;

  // squares of the accelerometer axes
  logic signed [31:0] ax_sq;
  logic signed [31:0] ay_sq;
  logic signed [31:0] az_sq;
  logic               v1_r;
  in_t                in1_r;
  logic [31:0]        sqp_r;
  logic [31:0]        sqr_r;

  assign ax_sq = in_item.accel_x * in_item.accel_x;
  assign ay_sq = in_item.accel_y * in_item.accel_y;
  assign az_sq = in_item.accel_z * in_item.accel_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    in1_r <= in_item;
    sqp_r <= unsigned'(az_sq) + unsigned'(ay_sq);
    sqr_r <= unsigned'(az_sq) + unsigned'(ax_sq);
  end

  // square roots of the tilt denominators
  logic        sqp_v;
  logic        sqr_v;
  logic [31:0] sp;
  logic [31:0] sr;

  tcc_isqrt u_sqrt_p (
    .clk(clk), .rst_n(rst_n), .in_valid(v1_r), .sum_sq(sqp_r),
    .out_valid(sqp_v), .root(sp)
  );

  tcc_isqrt u_sqrt_r (
    .clk(clk), .rst_n(rst_n), .in_valid(v1_r), .sum_sq(sqr_r),
    .out_valid(sqr_v), .root(sr)
  );

  // accel x/y wait for the roots
  logic [31:0] axy_dly_r [AXY_DLY];

  always_ff @(posedge clk) begin
    axy_dly_r[0] <= {in1_r.accel_x, in1_r.accel_y};
    for (int i = 1; i < AXY_DLY; i++) begin
      axy_dly_r[i] <= axy_dly_r[i-1];
    end
  end

  // magnetometer waits for sin/cos
  logic [47:0] mag_dly_r [MAG_DLY];

  always_ff @(posedge clk) begin
    mag_dly_r[0] <= {in1_r.mag_x, in1_r.mag_y, in1_r.mag_z};
    for (int i = 1; i < MAG_DLY; i++) begin
      mag_dly_r[i] <= mag_dly_r[i-1];
    end
  end

  // pitch and roll atan2 operands
  logic signed [15:0]   ax_d;
  logic signed [15:0]   ay_d;
  logic signed [CW-1:0] yp_op;
  logic signed [CW-1:0] yr_op;
  logic signed [CW-1:0] xp_op;
  logic signed [CW-1:0] xr_op;

  assign ax_d  = signed'(axy_dly_r[AXY_DLY-1][31:16]);
  assign ay_d  = signed'(axy_dly_r[AXY_DLY-1][15:0]);
  assign yp_op = -(CW'(ax_d) <<< 16);
  assign yr_op = CW'(ay_d) <<< 16;
  assign xp_op = signed'(CW'(sp));
  assign xr_op = signed'(CW'(sr));

  logic                 ap_v;
  logic                 ar_v;
  logic signed [AW-1:0] pitch;
  logic signed [AW-1:0] roll;

  tcc_atan2 u_atan_p (
    .clk(clk), .rst_n(rst_n), .in_valid(sqp_v & sqr_v), .y_in(yp_op),
    .x_in(xp_op), .out_valid(ap_v), .angle(pitch)
  );

  tcc_atan2 u_atan_r (
    .clk(clk), .rst_n(rst_n), .in_valid(sqp_v & sqr_v), .y_in(yr_op),
    .x_in(xr_op), .out_valid(ar_v), .angle(roll)
  );

  // pitch and roll wait for the heading
  logic [2*AW-1:0] pr_dly_r [PR_DLY];

  always_ff @(posedge clk) begin
    pr_dly_r[0] <= {pitch, roll};
    for (int i = 1; i < PR_DLY; i++) begin
      pr_dly_r[i] <= pr_dly_r[i-1];
    end
  end

  // sin and cos of pitch and roll
  logic                 scp_v;
  logic                 scr_v;
  logic signed [SW-1:0] cp;
  logic signed [SW-1:0] snp;
  logic signed [SW-1:0] cr;
  logic signed [SW-1:0] snr;

  tcc_sincos u_sc_p (
    .clk(clk), .rst_n(rst_n), .in_valid(ap_v & ar_v), .angle(pitch),
    .out_valid(scp_v), .cos_q(cp), .sin_q(snp)
  );

  tcc_sincos u_sc_r (
    .clk(clk), .rst_n(rst_n), .in_valid(ap_v & ar_v), .angle(roll),
    .out_valid(scr_v), .cos_q(cr), .sin_q(snr)
  );

  // first multiply stage: mag times sin/cos
  logic signed [15:0]   mx;
  logic signed [15:0]   my;
  logic signed [15:0]   mz;
  logic signed [MW-1:0] a1_nxt;
  logic signed [MW-1:0] a2_nxt;
  logic signed [MW-1:0] a3_nxt;
  logic signed [MW-1:0] a4_nxt;
  logic signed [MW-1:0] a5_nxt;
  logic signed [MW-1:0] a1_r;
  logic signed [MW-1:0] a2_r;
  logic signed [MW-1:0] a3_r;
  logic signed [MW-1:0] a4_r;
  logic signed [MW-1:0] a5_r;
  logic signed [SW-1:0] snp1_r;
  logic signed [SW-1:0] snp2_r;

  assign mx     = signed'(mag_dly_r[MAG_DLY-1][47:32]);
  assign my     = signed'(mag_dly_r[MAG_DLY-1][31:16]);
  assign mz     = signed'(mag_dly_r[MAG_DLY-1][15:0]);
  assign a1_nxt = my * snr;
  assign a2_nxt = mz * cr;
  assign a3_nxt = mx * cp;
  assign a4_nxt = my * cr;
  assign a5_nxt = mz * snr;

  always_ff @(posedge clk) begin
    a1_r   <= a1_nxt;
    a2_r   <= a2_nxt;
    a3_r   <= a3_nxt;
    a4_r   <= a4_nxt;
    a5_r   <= a5_nxt;
    snp1_r <= snp;
    snp2_r <= snp1_r;
  end

  // second stage: sums, yh done here
  logic signed [TW-1:0] t_r;
  logic signed [MW-1:0] xa_r;
  logic signed [TW-1:0] yh_r;

  always_ff @(posedge clk) begin
    t_r  <= TW'(a1_r) + TW'(a2_r);
    xa_r <= a3_r;
    yh_r <= TW'(a4_r) - TW'(a5_r);
  end

  // third stage: triple product with sin pitch
  logic signed [UW-1:0] u_nxt;
  logic signed [UW-1:0] u_r;
  logic signed [MW-1:0] xa2_r;
  logic signed [TW-1:0] yh2_r;

  assign u_nxt = t_r * snp2_r;

  always_ff @(posedge clk) begin
    u_r   <= u_nxt;
    xa2_r <= xa_r;
    yh2_r <= yh_r;
  end

  // fourth stage: horizontal field
  logic signed [UW-1:0] u_sh;
  logic signed [CW-1:0] xh_r;
  logic signed [CW-1:0] yh3_r;

  assign u_sh = u_r >>> 16;

  always_ff @(posedge clk) begin
    xh_r  <= CW'(xa2_r) + u_sh[CW-1:0];
    yh3_r <= CW'(yh2_r);
  end

  // mult pipeline valid bits
  logic [3:0] mv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= '0;
    end else begin
      mv_r <= {mv_r[2:0], scp_v & scr_v};
    end
  end

  // heading angle
  logic                 ah_v;
  logic signed [AW-1:0] head;

  tcc_atan2 u_atan_h (
    .clk(clk), .rst_n(rst_n), .in_valid(mv_r[3]), .y_in(yh3_r),
    .x_in(xh_r), .out_valid(ah_v), .angle(head)
  );

  // degree scaling: magnitude times 180/pi
  logic signed [AW-1:0] pitch_d;
  logic signed [AW-1:0] roll_d;
  logic signed [AW:0]   head_w;
  logic [AW:0]          pmag;
  logic [AW:0]          rmag;
  logic [AW:0]          hmag;
  logic                 d1_v_r;
  logic                 psgn_r;
  logic                 rsgn_r;
  logic [PW-1:0]        pprod_r;
  logic [PW-1:0]        rprod_r;
  logic [PW-1:0]        hprod_r;

  assign pitch_d = signed'(pr_dly_r[PR_DLY-1][2*AW-1:AW]);
  assign roll_d  = signed'(pr_dly_r[PR_DLY-1][AW-1:0]);
  assign head_w  = (head < 0) ? ((AW+1)'(head) + TWO_PI_Q16) : (AW+1)'(head);
  assign pmag    = (pitch_d < 0) ? unsigned'(-(AW+1)'(pitch_d)) : unsigned'((AW+1)'(pitch_d));
  assign rmag    = (roll_d < 0) ? unsigned'(-(AW+1)'(roll_d)) : unsigned'((AW+1)'(roll_d));
  assign hmag    = unsigned'(head_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r <= 1'b0;
    end else begin
      d1_v_r <= ah_v;
    end
  end

  always_ff @(posedge clk) begin
    psgn_r  <= pitch_d < 0;
    rsgn_r  <= roll_d < 0;
    pprod_r <= PW'(pmag) * PW'(DEG_MULT);
    rprod_r <= PW'(rmag) * PW'(DEG_MULT);
    hprod_r <= PW'(hmag) * PW'(DEG_MULT);
  end

  // truncate, clamp and sign
  logic [10:0] pdeg;
  logic [10:0] rdeg;
  logic [10:0] hdeg;
  logic [7:0]  pclip;
  logic [7:0]  rclip;
  out_t        out_nxt;
  out_t        out_item_r;
  logic        out_valid_r;

  assign pdeg  = pprod_r[PW-1:32];
  assign rdeg  = rprod_r[PW-1:32];
  assign hdeg  = hprod_r[PW-1:32];
  assign pclip = (pdeg > TILT_MAX) ? TILT_MAX[7:0] : pdeg[7:0];
  assign rclip = (rdeg > TILT_MAX) ? TILT_MAX[7:0] : rdeg[7:0];

  always_comb begin
    out_nxt.pitch_deg   = psgn_r ? -signed'(pclip) : signed'(pclip);
    out_nxt.roll_deg    = rsgn_r ? -signed'(rclip) : signed'(rclip);
    out_nxt.heading_deg = (hdeg > HEAD_MAX) ? HEAD_MAX[8:0] : hdeg[8:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= d1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ sim/tb_tilt_compensated_compass.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tilt_compensated_compass
// Drives magnetometer and accelerometer samples with random sender gaps,
// predicts pitch, roll and heading in fixed point, and checks every result
// in order against the predicted values.
// ----------------------------------------------------------------------------
module tb_tilt_compensated_compass;
  import tcc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 120;

  // expected headings and tilt angles, in item order
  class compass_scoreboard;
    out_t   pending[$];
    int     errors;
    int     checked;

    function automatic longint unsigned isqrt(longint unsigned n);
      longint unsigned res, bit_v;
      res   = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
        if (n >= res + bit_v) begin
          n   = n - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v >>= 2;
      end
      return res;
    endfunction

    // vectoring cordic, angle in q3.16 rad
    function automatic longint vec_angle(longint y, longint x);
      longint z, t, nx, ny;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = longint'(HALF_PI_Q16);
        end else begin
          t = x; x = -y; y = t; z = -longint'(HALF_PI_Q16);
        end
      end
      for (int i = 0; i < ITERS; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> i); ny = y - (x >>> i); z += longint'(ATAN_TAB[i]);
        end else begin
          nx = x - (y >>> i); ny = y + (x >>> i); z -= longint'(ATAN_TAB[i]);
        end
        x = nx; y = ny;
      end
      return z;
    endfunction

    // rotation cordic, cos and sin in q.16
    function automatic void rot_sincos(longint ang, output longint c, output longint s);
      longint x, y, z, nx, ny;
      x = longint'(CORDIC_XINIT); y = 0; z = ang;
      for (int i = 0; i < ITERS; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i); ny = y + (x >>> i); z -= longint'(ATAN_TAB[i]);
        end else begin
          nx = x + (y >>> i); ny = y - (x >>> i); z += longint'(ATAN_TAB[i]);
        end
        x = nx; y = ny;
      end
      c = x; s = y;
    endfunction

    function automatic longint rad_to_deg(longint z);
      if (z < 0) return -(((-z) * longint'(DEG_MULT)) >>> 32);
      return (z * longint'(DEG_MULT)) >>> 32;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic out_t compass_predict(in_t s);
      longint mx, my, mz, ax, ay, az, sp, sr, p, r, cp, snp, cr, snr, xh, yh, hd;
      out_t o;
      mx = s.mag_x;   my = s.mag_y;   mz = s.mag_z;
      ax = s.accel_x; ay = s.accel_y; az = s.accel_z;
      sp = longint'(isqrt(longint'(az * az + ay * ay) << 32));
      sr = longint'(isqrt(longint'(az * az + ax * ax) << 32));
      p  = vec_angle(-ax * 65536, sp);
      r  = vec_angle(ay * 65536, sr);
      rot_sincos(p, cp, snp);
      rot_sincos(r, cr, snr);
      xh = mx * cp + ((my * snr * snp + mz * cr * snp) >>> 16);
      yh = my * cr - mz * snr;
      hd = vec_angle(yh, xh);
      if (hd < 0) hd += longint'(TWO_PI_Q16);
      o.pitch_deg   = 8'(clip(rad_to_deg(p), -90, 90));
      o.roll_deg    = 8'(clip(rad_to_deg(r), -90, 90));
      o.heading_deg = 9'(clip(rad_to_deg(hd), 0, 359));
      return o;
    endfunction

    function void note_sample(in_t s);
      pending.push_back(compass_predict(s));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        $error("result with nothing expected: %p", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.pitch_deg !== want.pitch_deg) begin
        $error("pitch_deg expected %0d got %0d", want.pitch_deg, got.pitch_deg);
        errors++;
      end
      if (got.roll_deg !== want.roll_deg) begin
        $error("roll_deg expected %0d got %0d", want.roll_deg, got.roll_deg);
        errors++;
      end
      if (got.heading_deg !== want.heading_deg) begin
        $error("heading_deg expected %0d got %0d", want.heading_deg, got.heading_deg);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_item = '0;
  logic out_valid;
  out_t out_item;

  compass_scoreboard sb = new();
  int idle_cycles = 0;
  int sent = 0;
  logic accepted;

  always #5 clk = ~clk;

  tilt_compensated_compass dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  // result monitor and watchdog
  always @(posedge clk) begin
    accepted = rst_n && start && !busy;
    if (rst_n && out_valid) sb.check_result(out_item);
    if (accepted || (rst_n && out_valid)) idle_cycles = 0;
    else if (rst_n) idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", sb.pending.size());
      $display("status: fail");
      $finish;
    end
  end

  // send one sample after a random gap
  task automatic send_sample(in_t s);
    int gap;
    gap = $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   = 1'b1;
    in_item = s;
    while (busy) @(negedge clk);
    @(posedge clk);
    sb.note_sample(s);
    sent++;
  endtask

  function automatic in_t make_sample(int mx, int my, int mz, int ax, int ay, int az);
    in_t s;
    s.mag_x = 16'(mx);   s.mag_y = 16'(my);   s.mag_z = 16'(mz);
    s.accel_x = 16'(ax); s.accel_y = 16'(ay); s.accel_z = 16'(az);
    return s;
  endfunction

  function automatic int rnd16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int rnd_span(int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  initial begin
    in_t s;
    int  kind, g;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: zero vectors, extremes, quadrants, steep tilt
    send_sample(make_sample(0, 0, 0, 0, 0, 0));
    send_sample(make_sample(1000, 0, 0, 0, 0, 0));
    send_sample(make_sample(0, 0, 0, 0, 0, 16384));
    send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
    send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 32767));
    send_sample(make_sample(-32768, 32767, -32768, 32767, -32768, 32767));
    send_sample(make_sample(1000, 0, 0, 0, 0, 16384));
    send_sample(make_sample(0, 1000, 0, 0, 0, 16384));
    send_sample(make_sample(-1000, 0, 0, 0, 0, 16384));
    send_sample(make_sample(-1000, 1, 0, 0, 0, 16384));
    send_sample(make_sample(-1000, -1, 0, 0, 0, 16384));
    send_sample(make_sample(0, -1000, 0, 0, 0, 16384));
    send_sample(make_sample(500, 300, 200, 16384, 0, 0));
    send_sample(make_sample(500, 300, 200, -16384, 0, 0));
    send_sample(make_sample(500, 300, 200, 0, 16384, 0));
    send_sample(make_sample(500, 300, 200, 0, -16384, 0));
    send_sample(make_sample(500, 300, 200, 0, 0, -16384));
    send_sample(make_sample(300, -200, 400, 5000, -7000, -12000));
    send_sample(make_sample(-32768, 0, 0, -32768, 0, 0));
    send_sample(make_sample(32767, -32768, 32767, 0, 32767, -32768));

    // random: mostly gravity-sized accel, some full-range noise
    for (int i = 0; i < 700; i++) begin
      kind = $urandom_range(0, 9);
      g    = $urandom_range(0, 3) == 0 ? 32767 : 17000;
      if (kind < 7)
        s = make_sample(rnd_span(4000), rnd_span(4000), rnd_span(4000),
                        rnd_span(g), rnd_span(g), rnd_span(g));
      else if (kind < 9)
        s = make_sample(rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
      else
        s = make_sample(rnd_span(3), rnd_span(3), rnd_span(3),
                        rnd_span(3), rnd_span(3), rnd_span(3));
      send_sample(s);
      if (i == 350) begin
        @(negedge clk);
        start = 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
    end
    @(negedge clk);
    start = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d samples: zero vectors, axis extremes, all heading quadrants,",
             sent);
    $display("steep tilt and random sensor data; %0d results compared", sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

@@ tilt_compensated_compass.f @@
hdl/tcc_pkg.sv
hdl/tcc_isqrt.sv
hdl/tcc_atan2.sv
hdl/tcc_sincos.sv
hdl/tilt_compensated_compass.sv
sim/tb_tilt_compensated_compass.sv
